// ===== rtl/ffha_pkg.sv =====
// Shared types and codes for the first-fit heap allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package ffha_pkg;

	// operation codes on the request channel
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_TRIM  = 2'd2;

	// status codes on the result channel
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	// result offset width, fixed by the result format
	localparam int RES_W = 12;

	// operand selects for addresses and written field values
	localparam logic [2:0] SEL_P    = 3'd0;
	localparam logic [2:0] SEL_P2   = 3'd1;
	localparam logic [2:0] SEL_X    = 3'd2;
	localparam logic [2:0] SEL_Y    = 3'd3;
	localparam logic [2:0] SEL_PV   = 3'd4;
	localparam logic [2:0] SEL_LF   = 3'd5;
	localparam logic [2:0] SEL_END  = 3'd6;
	localparam logic [2:0] SEL_ZERO = 3'd7;

	// register load operations
	localparam logic [3:0] LD_NONE     = 4'd0;
	localparam logic [3:0] LD_START    = 4'd1;
	localparam logic [3:0] LD_X_RNEXT  = 4'd2;
	localparam logic [3:0] LD_Y_RNEXT  = 4'd3;
	localparam logic [3:0] LD_PV_RPREV = 4'd4;
	localparam logic [3:0] LD_P_X      = 4'd5;
	localparam logic [3:0] LD_P2       = 4'd6;
	localparam logic [3:0] LD_LF_P     = 4'd7;
	localparam logic [3:0] LD_LF_PV    = 4'd8;
	localparam logic [3:0] LD_LF_P2    = 4'd9;
	localparam logic [3:0] LD_LF_RNEXT = 4'd10;
	localparam logic [3:0] LD_RES      = 4'd11;

	// result offset selects
	localparam logic [1:0] RS_NONE = 2'd0;
	localparam logic [1:0] RS_P    = 2'd1;
	localparam logic [1:0] RS_DATA = 2'd2;

	// command from controller to datapath
	typedef struct packed {
		logic       rd;
		logic [2:0] asel;
		logic       wr;
		logic [2:0] wsel;
		logic       set_next;
		logic [2:0] nsel;
		logic       set_prev;
		logic [2:0] psel;
		logic       set_used;
		logic       used_val;
		logic [3:0] ld;
		logic [1:0] st;
		logic [1:0] rsel;
		logic       push;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       zero_req;
		logic       big;
		logic       bad_off;
		logic       in_lim;
		logic       fit;
		logic       split;
		logic       gt;
		logic       eq;
		logic       used;
		logic       rnext_le_lf;
		logic       x_le_p;
		logic       x_is_end;
		logic       y_is_end;
		logic       x_eq_p;
		logic       pv_eq_p;
		logic       lf_eq_x;
		logic       lf_eq_p;
		logic       lf_is_end;
		logic       p_lt_lf;
		logic       p2_lt_lf;
		logic       p_eq_lf;
		logic       out_free;
	} flags_t;

endpackage

// ===== rtl/ffha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read data holds until the next read.
module ffha_ram #(
	parameter int W = 27,
	parameter int D = 1025
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/ffha_ctrl.sv =====
// Sequencer for the allocator: walks allocate, free and trim as steps of
// header reads and read-modify-writes. Depends on ffha_pkg.
module ffha_ctrl import ffha_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   s_tvalid,
	output logic   s_tready,
	input  flags_t flg,
	output cmd_t   cmd
);

	localparam logic [5:0] S_INIT0 = 6'd0;
	localparam logic [5:0] S_INIT1 = 6'd1;
	localparam logic [5:0] S_IDLE  = 6'd2;
	localparam logic [5:0] S_DISP  = 6'd3;
	localparam logic [5:0] S_A_RD  = 6'd4;
	localparam logic [5:0] S_A_CHK = 6'd5;
	localparam logic [5:0] S_A_DEC = 6'd6;
	localparam logic [5:0] S_A_P2  = 6'd7;
	localparam logic [5:0] S_A_W2  = 6'd8;
	localparam logic [5:0] S_A_WP  = 6'd9;
	localparam logic [5:0] S_A_RX  = 6'd10;
	localparam logic [5:0] S_A_WX  = 6'd11;
	localparam logic [5:0] S_A_NS  = 6'd12;
	localparam logic [5:0] S_A_LF  = 6'd13;
	localparam logic [5:0] S_L_RD  = 6'd14;
	localparam logic [5:0] S_L_CHK = 6'd15;
	localparam logic [5:0] S_F_RD  = 6'd16;
	localparam logic [5:0] S_F_CHK = 6'd17;
	localparam logic [5:0] S_F_W   = 6'd18;
	localparam logic [5:0] S_F_M1  = 6'd19;
	localparam logic [5:0] S_F_M2  = 6'd20;
	localparam logic [5:0] S_F_M3  = 6'd21;
	localparam logic [5:0] S_F_M4  = 6'd22;
	localparam logic [5:0] S_F_M5  = 6'd23;
	localparam logic [5:0] S_F_M6  = 6'd24;
	localparam logic [5:0] S_F_P   = 6'd25;
	localparam logic [5:0] S_F_P1  = 6'd26;
	localparam logic [5:0] S_F_P2  = 6'd27;
	localparam logic [5:0] S_F_P3  = 6'd28;
	localparam logic [5:0] S_F_P4  = 6'd29;
	localparam logic [5:0] S_F_P5  = 6'd30;
	localparam logic [5:0] S_F_P6  = 6'd31;
	localparam logic [5:0] S_F_P7  = 6'd32;
	localparam logic [5:0] S_F_P8  = 6'd33;
	localparam logic [5:0] S_F_P9  = 6'd34;
	localparam logic [5:0] S_T_RD  = 6'd35;
	localparam logic [5:0] S_T_CHK = 6'd36;
	localparam logic [5:0] S_T_C2  = 6'd37;
	localparam logic [5:0] S_T_RX  = 6'd38;
	localparam logic [5:0] S_T_C3  = 6'd39;
	localparam logic [5:0] S_T_A1  = 6'd40;
	localparam logic [5:0] S_T_A3  = 6'd41;
	localparam logic [5:0] S_T_A4  = 6'd42;
	localparam logic [5:0] S_T_A5  = 6'd43;
	localparam logic [5:0] S_T_A6  = 6'd44;
	localparam logic [5:0] S_T_B1  = 6'd45;
	localparam logic [5:0] S_T_B2  = 6'd46;
	localparam logic [5:0] S_T_B3  = 6'd47;
	localparam logic [5:0] S_T_B4  = 6'd48;
	localparam logic [5:0] S_T_B5  = 6'd49;
	localparam logic [5:0] S_OUT   = 6'd50;

	logic [5:0] state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT0;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			// write the first and end headers after reset
			S_INIT0: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_ZERO;
				cmd.set_next = 1'b1; cmd.nsel = SEL_END;
				cmd.set_prev = 1'b1; cmd.psel = SEL_ZERO;
				cmd.set_used = 1'b1; cmd.used_val = 1'b0;
				state_d = S_INIT1;
			end
			S_INIT1: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_END;
				cmd.set_next = 1'b1; cmd.nsel = SEL_END;
				cmd.set_prev = 1'b1; cmd.psel = SEL_END;
				cmd.set_used = 1'b1; cmd.used_val = 1'b1;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.ld = LD_START;
					state_d = S_DISP;
				end
			end
			// check the request before touching the store
			S_DISP: begin
				case (flg.op)
					OP_ALLOC: begin
						if (flg.zero_req || flg.big) begin
							cmd.ld = LD_RES; cmd.st = ST_REFUSED;
							state_d = S_OUT;
						end else begin
							state_d = S_A_RD;
						end
					end
					OP_FREE: begin
						if (flg.bad_off) begin
							cmd.ld = LD_RES; cmd.st = ST_IGNORED;
							state_d = S_OUT;
						end else begin
							state_d = S_F_RD;
						end
					end
					OP_TRIM: begin
						if (flg.big) begin
							cmd.ld = LD_RES; cmd.st = ST_REFUSED;
							state_d = S_OUT;
						end else if (flg.bad_off) begin
							cmd.ld = LD_RES; cmd.st = ST_IGNORED;
							state_d = S_OUT;
						end else begin
							state_d = S_T_RD;
						end
					end
					default: begin
						cmd.ld = LD_RES; cmd.st = ST_IGNORED;
						state_d = S_OUT;
					end
				endcase
			end
			// allocate: first-fit walk
			S_A_RD: begin
				if (flg.in_lim) begin
					cmd.rd = 1'b1; cmd.asel = SEL_P;
					state_d = S_A_CHK;
				end else begin
					cmd.ld = LD_RES; cmd.st = ST_REFUSED;
					state_d = S_OUT;
				end
			end
			S_A_CHK: begin
				cmd.ld = LD_X_RNEXT;
				state_d = S_A_DEC;
			end
			S_A_DEC: begin
				if (!flg.used && flg.fit) begin
					state_d = flg.split ? S_A_P2 : S_A_NS;
				end else if (flg.x_le_p) begin
					cmd.ld = LD_RES; cmd.st = ST_REFUSED;
					state_d = S_OUT;
				end else begin
					cmd.ld = LD_P_X;
					state_d = S_A_RD;
				end
			end
			S_A_P2: begin
				cmd.ld = LD_P2;
				state_d = S_A_W2;
			end
			S_A_W2: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_P2;
				cmd.set_next = 1'b1; cmd.nsel = SEL_X;
				cmd.set_prev = 1'b1; cmd.psel = SEL_P;
				cmd.set_used = 1'b1; cmd.used_val = 1'b0;
				state_d = S_A_WP;
			end
			S_A_WP: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_P;
				cmd.set_next = 1'b1; cmd.nsel = SEL_P2;
				cmd.set_used = 1'b1; cmd.used_val = 1'b1;
				state_d = flg.x_is_end ? S_A_LF : S_A_RX;
			end
			S_A_RX: begin
				cmd.rd = 1'b1; cmd.asel = SEL_X;
				state_d = S_A_WX;
			end
			S_A_WX: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_X;
				cmd.set_prev = 1'b1; cmd.psel = SEL_P2;
				state_d = S_A_LF;
			end
			S_A_NS: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_P;
				cmd.set_used = 1'b1; cmd.used_val = 1'b1;
				state_d = S_A_LF;
			end
			S_A_LF: begin
				if (flg.p_eq_lf) begin
					state_d = S_L_RD;
				end else begin
					cmd.ld = LD_RES; cmd.st = ST_DONE; cmd.rsel = RS_P;
					state_d = S_OUT;
				end
			end
			// advance the lowest-free pointer past used blocks
			S_L_RD: begin
				cmd.rd = 1'b1; cmd.asel = SEL_LF;
				state_d = S_L_CHK;
			end
			S_L_CHK: begin
				if (!flg.used || flg.lf_is_end || flg.rnext_le_lf) begin
					cmd.ld = LD_RES; cmd.st = ST_DONE; cmd.rsel = RS_P;
					state_d = S_OUT;
				end else begin
					cmd.ld = LD_LF_RNEXT;
					state_d = S_L_RD;
				end
			end
			// free: clear used bit
			S_F_RD: begin
				cmd.rd = 1'b1; cmd.asel = SEL_P;
				state_d = S_F_CHK;
			end
			S_F_CHK: begin
				if (!flg.used) begin
					cmd.ld = LD_RES; cmd.st = ST_IGNORED;
					state_d = S_OUT;
				end else begin
					cmd.ld = LD_X_RNEXT;
					state_d = S_F_W;
				end
			end
			S_F_W: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_P;
				cmd.set_used = 1'b1; cmd.used_val = 1'b0;
				cmd.ld = flg.p_lt_lf ? LD_LF_P : LD_NONE;
				state_d = S_F_M1;
			end
			// free: merge with a free successor
			S_F_M1: begin
				if (flg.x_eq_p || flg.x_is_end) begin
					state_d = S_F_P;
				end else begin
					cmd.rd = 1'b1; cmd.asel = SEL_X;
					state_d = S_F_M2;
				end
			end
			S_F_M2: begin
				if (flg.used) begin
					state_d = S_F_P;
				end else begin
					cmd.ld = LD_Y_RNEXT;
					state_d = S_F_M3;
				end
			end
			S_F_M3: begin
				cmd.ld = flg.lf_eq_x ? LD_LF_P : LD_NONE;
				cmd.rd = 1'b1; cmd.asel = SEL_P;
				state_d = S_F_M4;
			end
			S_F_M4: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_P;
				cmd.set_next = 1'b1; cmd.nsel = SEL_Y;
				state_d = S_F_M5;
			end
			S_F_M5: begin
				cmd.rd = 1'b1; cmd.asel = SEL_Y;
				state_d = S_F_M6;
			end
			S_F_M6: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_Y;
				cmd.set_prev = 1'b1; cmd.psel = SEL_P;
				state_d = S_F_P;
			end
			// free: merge into a free predecessor
			S_F_P: begin
				cmd.rd = 1'b1; cmd.asel = SEL_P;
				state_d = S_F_P1;
			end
			S_F_P1: begin
				cmd.ld = LD_PV_RPREV;
				state_d = S_F_P2;
			end
			S_F_P2: begin
				if (flg.pv_eq_p) begin
					cmd.ld = LD_RES; cmd.st = ST_DONE;
					state_d = S_OUT;
				end else begin
					cmd.rd = 1'b1; cmd.asel = SEL_PV;
					state_d = S_F_P3;
				end
			end
			S_F_P3: begin
				if (flg.used) begin
					cmd.ld = LD_RES; cmd.st = ST_DONE;
					state_d = S_OUT;
				end else begin
					cmd.ld = flg.lf_eq_p ? LD_LF_PV : LD_NONE;
					state_d = S_F_P4;
				end
			end
			S_F_P4: begin
				cmd.rd = 1'b1; cmd.asel = SEL_P;
				state_d = S_F_P5;
			end
			S_F_P5: begin
				cmd.ld = LD_Y_RNEXT;
				state_d = S_F_P6;
			end
			S_F_P6: begin
				cmd.rd = 1'b1; cmd.asel = SEL_PV;
				state_d = S_F_P7;
			end
			S_F_P7: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_PV;
				cmd.set_next = 1'b1; cmd.nsel = SEL_Y;
				state_d = S_F_P8;
			end
			S_F_P8: begin
				cmd.rd = 1'b1; cmd.asel = SEL_Y;
				state_d = S_F_P9;
			end
			S_F_P9: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_Y;
				cmd.set_prev = 1'b1; cmd.psel = SEL_PV;
				cmd.ld = LD_RES; cmd.st = ST_DONE;
				state_d = S_OUT;
			end
			// trim: check sizes
			S_T_RD: begin
				cmd.rd = 1'b1; cmd.asel = SEL_P;
				state_d = S_T_CHK;
			end
			S_T_CHK: begin
				if (!flg.used) begin
					cmd.ld = LD_RES; cmd.st = ST_IGNORED;
					state_d = S_OUT;
				end else begin
					cmd.ld = LD_X_RNEXT;
					state_d = S_T_C2;
				end
			end
			S_T_C2: begin
				if (flg.gt) begin
					cmd.ld = LD_RES; cmd.st = ST_REFUSED;
					state_d = S_OUT;
				end else if (flg.eq) begin
					cmd.ld = LD_RES; cmd.st = ST_DONE; cmd.rsel = RS_DATA;
					state_d = S_OUT;
				end else begin
					cmd.ld = LD_P2;
					state_d = S_T_RX;
				end
			end
			S_T_RX: begin
				cmd.rd = 1'b1; cmd.asel = SEL_X;
				state_d = S_T_C3;
			end
			S_T_C3: begin
				if (!flg.used) begin
					cmd.ld = LD_Y_RNEXT;
					state_d = S_T_A1;
				end else if (flg.split) begin
					state_d = S_T_B1;
				end else begin
					cmd.ld = LD_RES; cmd.st = ST_DONE; cmd.rsel = RS_DATA;
					state_d = S_OUT;
				end
			end
			// trim: tail joins the free successor
			S_T_A1: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_P2;
				cmd.set_next = 1'b1; cmd.nsel = SEL_Y;
				cmd.set_prev = 1'b1; cmd.psel = SEL_P;
				cmd.set_used = 1'b1; cmd.used_val = 1'b0;
				cmd.ld = flg.lf_eq_x ? LD_LF_P2 : LD_NONE;
				state_d = S_T_A3;
			end
			S_T_A3: begin
				cmd.rd = 1'b1; cmd.asel = SEL_P;
				state_d = S_T_A4;
			end
			S_T_A4: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_P;
				cmd.set_next = 1'b1; cmd.nsel = SEL_P2;
				if (flg.y_is_end) begin
					cmd.ld = LD_RES; cmd.st = ST_DONE; cmd.rsel = RS_DATA;
					state_d = S_OUT;
				end else begin
					state_d = S_T_A5;
				end
			end
			S_T_A5: begin
				cmd.rd = 1'b1; cmd.asel = SEL_Y;
				state_d = S_T_A6;
			end
			S_T_A6: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_Y;
				cmd.set_prev = 1'b1; cmd.psel = SEL_P2;
				cmd.ld = LD_RES; cmd.st = ST_DONE; cmd.rsel = RS_DATA;
				state_d = S_OUT;
			end
			// trim: tail split off as a new free block
			S_T_B1: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_P2;
				cmd.set_next = 1'b1; cmd.nsel = SEL_X;
				cmd.set_prev = 1'b1; cmd.psel = SEL_P;
				cmd.set_used = 1'b1; cmd.used_val = 1'b0;
				cmd.ld = flg.p2_lt_lf ? LD_LF_P2 : LD_NONE;
				state_d = S_T_B2;
			end
			S_T_B2: begin
				cmd.rd = 1'b1; cmd.asel = SEL_P;
				state_d = S_T_B3;
			end
			S_T_B3: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_P;
				cmd.set_next = 1'b1; cmd.nsel = SEL_P2;
				if (flg.x_is_end) begin
					cmd.ld = LD_RES; cmd.st = ST_DONE; cmd.rsel = RS_DATA;
					state_d = S_OUT;
				end else begin
					state_d = S_T_B4;
				end
			end
			S_T_B4: begin
				cmd.rd = 1'b1; cmd.asel = SEL_X;
				state_d = S_T_B5;
			end
			S_T_B5: begin
				cmd.wr = 1'b1; cmd.wsel = SEL_X;
				cmd.set_prev = 1'b1; cmd.psel = SEL_P2;
				cmd.ld = LD_RES; cmd.st = ST_DONE; cmd.rsel = RS_DATA;
				state_d = S_OUT;
			end
			// hand the result to the output register
			S_OUT: begin
				if (flg.out_free) begin
					cmd.push = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/ffha_dp.sv =====
// Datapath for the allocator: working offsets, lowest-free pointer, header
// store, size compares and the result register. Depends on ffha_pkg, ffha_ram.
module ffha_dp import ffha_pkg::*; #(
	parameter int HEAP_BYTES      = 4096,
	parameter int ALIGN_BYTES     = 4,
	parameter int HEADER_BYTES    = 8,
	parameter int MIN_BLOCK_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output flags_t      flg,
	input  logic [31:0] s_tdata,
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic [1:0]  m_tuser
);

	localparam int HDR   = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	localparam int MINSZ = ((MIN_BLOCK_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	localparam int HEND  = ((HEAP_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	localparam int SLOTS = HEND / ALIGN_BYTES + 1;
	localparam int OW    = $clog2(HEND + 1);
	localparam int SIW   = $clog2(SLOTS);
	localparam int HW    = 2 * OW + 1;
	localparam int WW    = 18;
	localparam int SZW   = 17;
	localparam logic [OW-1:0] END_O = OW'(HEND);
	localparam logic [WW-1:0] END_W = WW'(HEND);
	localparam logic [WW-1:0] HDR_W = WW'(HDR);
	localparam logic [WW-1:0] MIN_W = WW'(MINSZ);

	logic [1:0]     op_q;
	logic           zero_q;
	logic [SZW-1:0] size_q;
	logic [15:0]    data_q;
	logic [OW-1:0]  p_q, p2_q, x_q, y_q, pv_q, lf_q;
	logic           rvld_q;
	logic [1:0]     rst_q;
	logic [RES_W-1:0] roff_q;
	logic           mv_q;
	logic [1:0]     mst_q;
	logic [RES_W-1:0] moff_q;

	logic [HW-1:0]  rdata;
	logic [OW-1:0]  rh_next, rh_prev;
	logic           rh_used;
	logic [OW-1:0]  rd_off, wr_off, nval, pval;
	logic [HW-1:0]  wdata;
	logic           we;
	logic [WW-1:0]  req_w, rup_w, size_w, pw, xw, bsize, sz_w, data_w, p2_w;

	function automatic logic [OW-1:0] pick(input logic [2:0] s,
		input logic [OW-1:0] p, input logic [OW-1:0] p2, input logic [OW-1:0] x,
		input logic [OW-1:0] y, input logic [OW-1:0] pv, input logic [OW-1:0] lf);
		logic [OW-1:0] v;
		case (s)
			SEL_P:   v = p;
			SEL_P2:  v = p2;
			SEL_X:   v = x;
			SEL_Y:   v = y;
			SEL_PV:  v = pv;
			SEL_LF:  v = lf;
			SEL_END: v = END_O;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic slot_ok(input logic [OW-1:0] off);
		return (off <= END_O) && ((off % ALIGN_BYTES) == 0);
	endfunction

	function automatic logic [SIW-1:0] slot_of(input logic [OW-1:0] off);
		return SIW'(off / ALIGN_BYTES);
	endfunction

	// operand selection
	always_comb begin
		rd_off = pick(cmd.asel, p_q, p2_q, x_q, y_q, pv_q, lf_q);
		wr_off = pick(cmd.wsel, p_q, p2_q, x_q, y_q, pv_q, lf_q);
		nval   = pick(cmd.nsel, p_q, p2_q, x_q, y_q, pv_q, lf_q);
		pval   = pick(cmd.psel, p_q, p2_q, x_q, y_q, pv_q, lf_q);
	end

	// header read: out-of-range reads give the end header
	assign rh_next = rvld_q ? rdata[HW-1 -: OW] : END_O;
	assign rh_prev = rvld_q ? rdata[OW:1] : END_O;
	assign rh_used = rvld_q ? rdata[0] : 1'b1;

	// header write merges new fields into the last read header
	assign wdata = {cmd.set_next ? nval : rh_next,
	                cmd.set_prev ? pval : rh_prev,
	                cmd.set_used ? cmd.used_val : rh_used};
	assign we = cmd.wr && slot_ok(wr_off);

	ffha_ram #(
		.W(HW),
		.D(SLOTS)
	) u_hdr_ram (
		.clk   (clk),
		.we    (we),
		.waddr (slot_of(wr_off)),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (slot_of(rd_off)),
		.rdata (rdata)
	);

	// size rounding on the incoming request
	assign req_w  = {2'b00, s_tdata[15:0]};
	assign rup_w  = WW'(((req_w + WW'(ALIGN_BYTES - 1)) / ALIGN_BYTES) * ALIGN_BYTES);
	assign size_w = (rup_w < MIN_W) ? MIN_W : rup_w;

	// block size of the block at p, from its next link in x
	assign pw     = WW'(p_q);
	assign xw     = WW'(x_q);
	assign sz_w   = WW'(size_q);
	assign data_w = WW'(data_q);
	assign bsize  = (xw >= pw + HDR_W) ? xw - pw - HDR_W : '0;
	assign p2_w   = pw + HDR_W + sz_w;

	// status to the controller
	always_comb begin
		flg             = '0;
		flg.op          = op_q;
		flg.zero_req    = zero_q;
		flg.big         = sz_w > END_W;
		flg.bad_off     = (data_w < HDR_W) || (data_w >= END_W)
		                  || (((data_w - HDR_W) % ALIGN_BYTES) != 0);
		flg.in_lim      = (pw + sz_w) < END_W;
		flg.fit         = bsize >= sz_w;
		flg.split       = bsize >= sz_w + HDR_W + MIN_W;
		flg.gt          = sz_w > bsize;
		flg.eq          = sz_w == bsize;
		flg.used        = rh_used;
		flg.rnext_le_lf = rh_next <= lf_q;
		flg.x_le_p      = x_q <= p_q;
		flg.x_is_end    = x_q == END_O;
		flg.y_is_end    = y_q == END_O;
		flg.x_eq_p      = x_q == p_q;
		flg.pv_eq_p     = pv_q == p_q;
		flg.lf_eq_x     = lf_q == x_q;
		flg.lf_eq_p     = lf_q == p_q;
		flg.lf_is_end   = lf_q == END_O;
		flg.p_lt_lf     = p_q < lf_q;
		flg.p2_lt_lf    = p2_q < lf_q;
		flg.p_eq_lf     = p_q == lf_q;
		flg.out_free    = !mv_q || m_tready;
	end

	// control state: read valid, lowest-free pointer, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_q <= 1'b0;
			lf_q   <= '0;
			mv_q   <= 1'b0;
		end else begin
			if (cmd.rd) begin
				rvld_q <= slot_ok(rd_off);
			end
			case (cmd.ld)
				LD_LF_P:     lf_q <= p_q;
				LD_LF_PV:    lf_q <= pv_q;
				LD_LF_P2:    lf_q <= p2_q;
				LD_LF_RNEXT: lf_q <= rh_next;
				default:     lf_q <= lf_q;
			endcase
			if (cmd.push) begin
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.ld)
			LD_START: begin
				op_q   <= s_tuser;
				zero_q <= (s_tdata[15:0] == 16'd0);
				size_q <= size_w[SZW-1:0];
				data_q <= s_tdata[31:16];
				if (s_tuser == OP_ALLOC) begin
					p_q <= lf_q;
				end else begin
					p_q <= OW'(WW'(s_tdata[31:16]) - HDR_W);
				end
			end
			LD_X_RNEXT:  x_q  <= rh_next;
			LD_Y_RNEXT:  y_q  <= rh_next;
			LD_PV_RPREV: pv_q <= rh_prev;
			LD_P_X:      p_q  <= x_q;
			LD_P2:       p2_q <= p2_w[OW-1:0];
			LD_RES: begin
				rst_q <= cmd.st;
				case (cmd.rsel)
					RS_P:    roff_q <= RES_W'(pw + HDR_W);
					RS_DATA: roff_q <= data_q[RES_W-1:0];
					default: roff_q <= '0;
				endcase
			end
			default: begin
			end
		endcase
		if (cmd.push) begin
			mst_q  <= rst_q;
			moff_q <= roff_q;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tuser  = mst_q;
	assign m_tdata  = {{(16 - RES_W){1'b0}}, moff_q};

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator with coalescing: block headers in an on-chip
// header RAM, driven by a sequencer. Depends on ffha_pkg, ffha_ctrl, ffha_dp.
//
// Request channel (s_*): one beat carries an operation in s_tuser
// (allocate, free, trim) with a size and a data offset in s_tdata.
// Result channel (m_*): one beat per request, status in m_tuser and the
// data offset of the allocated or trimmed block in m_tdata.
// One request is worked at a time; s_tready is high only while the
// sequencer is idle. Requests answered on their fields alone do not touch
// the header RAM. Allocate walks the header RAM in first-fit order, one
// read per block visited, and may then advance the lowest-free pointer
// past used headers; with setup and header writes around the walk. Free
// and trim read and rewrite the headers of the block and its neighbours.
// After reset the first and end headers are written before the first
// request is taken. A stalled result waits in the output register;
// the next result is held inside until that beat is taken.
module first_fit_heap_allocator import ffha_pkg::*; #(
	parameter int HEAP_BYTES      = 4096,
	parameter int ALIGN_BYTES     = 4,
	parameter int HEADER_BYTES    = 8,
	parameter int MIN_BLOCK_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // req_size[15:0], data_offset[31:16]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // result_offset[11:0], zero[15:12]
	output logic [1:0]  m_tuser   // status[1:0]
);

	cmd_t   cmd;
	flags_t flg;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.flg      (flg),
		.cmd      (cmd)
	);

	ffha_dp #(
		.HEAP_BYTES      (HEAP_BYTES),
		.ALIGN_BYTES     (ALIGN_BYTES),
		.HEADER_BYTES    (HEADER_BYTES),
		.MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.flg      (flg),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
